// File: rtl/btb_pkg.sv
// ---------------------------------------------------------------------------
// btb_pkg: shared types and constants of the branch target buffer
// entry layout, command codes, counter codes and lookup result struct
// ---------------------------------------------------------------------------
package btb_pkg;

  localparam int ADDR_W = 32;
  localparam int WORD_W = ADDR_W - 2;

  typedef enum logic {
    CMD_PREDICT = 1'b0,
    CMD_UPDATE  = 1'b1
  } cmd_t;

  // 2-bit counter codes
  localparam logic [1:0] CTR_STRONG_NT = 2'd0;
  localparam logic [1:0] CTR_WEAK_NT   = 2'd1;
  localparam logic [1:0] CTR_WEAK_T    = 2'd2;
  localparam logic [1:0] CTR_STRONG_T  = 2'd3;

  localparam logic [ADDR_W-1:0] INST_BYTES = ADDR_W'(4);

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] tag;
    logic [ADDR_W-1:0] target;
    logic [1:0]        counter;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              predict_taken;
    logic [ADDR_W-1:0] next_addr;
    entry_t            wr_entry;
  } eval_t;

endpackage

// File: rtl/btb_req_if.sv
// ---------------------------------------------------------------------------
// btb_req_if: request channel of the branch target buffer
// valid/ready handshake carrying predict and update transactions
// ---------------------------------------------------------------------------
interface btb_req_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [btb_pkg::ADDR_W-1:0] inst_addr;
  logic                      was_taken;
  logic [btb_pkg::ADDR_W-1:0] actual_target;

  modport source (output valid, cmd, inst_addr, was_taken, actual_target, input ready);
  modport sink   (input valid, cmd, inst_addr, was_taken, actual_target, output ready);
endinterface

// File: rtl/btb_rsp_if.sv
// ---------------------------------------------------------------------------
// btb_rsp_if: response channel of the branch target buffer
// valid/ready handshake carrying one prediction per transaction
// ---------------------------------------------------------------------------
interface btb_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      predict_taken;
  logic [btb_pkg::ADDR_W-1:0] next_addr;

  modport source (output valid, predict_taken, next_addr, input ready);
  modport sink   (input valid, predict_taken, next_addr, output ready);
endinterface

// File: rtl/btb_ram.sv
// ---------------------------------------------------------------------------
// btb_ram: generic single-clock ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module btb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/btb_slot.sv
// ---------------------------------------------------------------------------
// btb_slot: table index from a word address
// word modulo ENTRIES by reciprocal multiply, product registered
// ---------------------------------------------------------------------------
module btb_slot #(
  parameter int ENTRIES = 1024
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic [btb_pkg::WORD_W-1:0] word,
  output logic [$clog2(ENTRIES)-1:0] slot
);
  import btb_pkg::*;

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int SH      = WORD_W + IDX_W;
  localparam int RECIP_W = WORD_W + 2;
  localparam int PROD_W  = WORD_W + RECIP_W;
  localparam int Q_W     = PROD_W - SH;
  localparam logic [63:0] RECIP_64 = ((64'd1 << SH) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_64[RECIP_W-1:0];
  localparam logic [IDX_W:0]     ENT_K = (IDX_W + 1)'(ENTRIES);

  logic [PROD_W-1:0]    prod;
  logic [WORD_W-1:0]    word_q;
  logic [Q_W-1:0]       quot;
  logic [Q_W+IDX_W:0]   quot_ent;

  always_ff @(posedge clk) begin
    if (load) begin
      prod   <= PROD_W'(word) * PROD_W'(RECIP);
      word_q <= word;
    end
  end

  // quotient is exact, so the remainder fits the low index bits
  assign quot     = prod[PROD_W-1:SH];
  assign quot_ent = (Q_W + IDX_W + 1)'(quot) * (Q_W + IDX_W + 1)'(ENT_K);
  assign slot     = word_q[IDX_W-1:0] - quot_ent[IDX_W-1:0];

endmodule

// File: rtl/btb_eval.sv
// ---------------------------------------------------------------------------
// btb_eval: hit check, prediction and counter training
// works on the entry read back from the table
// ---------------------------------------------------------------------------
module btb_eval (
  input  btb_pkg::entry_t            rd_entry,
  input  logic [btb_pkg::ADDR_W-1:0] inst_addr,
  input  logic                       was_taken,
  input  logic [btb_pkg::ADDR_W-1:0] actual_target,
  output btb_pkg::eval_t             result
);
  import btb_pkg::*;

  logic       hit;
  logic [1:0] ctr_next;

  assign hit = rd_entry.valid && (rd_entry.tag == inst_addr);

  always_comb begin
    if (!hit) begin
      ctr_next = was_taken ? CTR_WEAK_NT : CTR_STRONG_NT;
    end else if (was_taken) begin
      ctr_next = (rd_entry.counter == CTR_STRONG_NT) ? CTR_WEAK_NT : CTR_STRONG_T;
    end else begin
      ctr_next = (rd_entry.counter == CTR_STRONG_T) ? CTR_WEAK_T : CTR_STRONG_NT;
    end
  end

  always_comb begin
    result.predict_taken    = hit && (rd_entry.counter >= CTR_WEAK_T);
    result.next_addr        = result.predict_taken ? rd_entry.target
                                                   : inst_addr + INST_BYTES;
    result.wr_entry.valid   = 1'b1;
    result.wr_entry.tag     = inst_addr;
    result.wr_entry.target  = actual_target;
    result.wr_entry.counter = ctr_next;
  end

endmodule

// File: rtl/btb_two_bit_branch_predictor_top.sv
// ---------------------------------------------------------------------------
// btb_two_bit_branch_predictor_top: direct-mapped btb with 2-bit counters
// flow: a transaction is accepted only in idle; the index product is
//   registered, the entry ram is read in the index state, and the lookup
//   state evaluates it, writes back an update or loads the response register
//   for a prediction; no new transaction is taken before the last finishes,
//   and a prediction stays in lookup while a held response blocks it
// reset: a clearing pass writes every entry invalid, no request is
//   taken until it ends; the response register resets empty
// ---------------------------------------------------------------------------
module btb_two_bit_branch_predictor_top #(
  parameter int ENTRIES = 1024
) (
  input  logic         clk,
  input  logic         rst,
  btb_req_if.sink      req,
  btb_rsp_if.source    rsp
);
  import btb_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_LOOKUP
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  clr_idx;

  // request held for the duration of the lookup
  cmd_t              cmd_q;
  logic [ADDR_W-1:0] addr_q;
  logic              taken_q;
  logic [ADDR_W-1:0] target_q;

  logic              req_fire;
  logic [IDX_W-1:0]  slot;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  entry_t            rd_entry;
  eval_t             eval;
  logic              rsp_load;
  logic              lookup_done;

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;

  // index computation: product registered at accept, remainder next cycle
  btb_slot #(
    .ENTRIES (ENTRIES)
  ) u_slot (
    .clk  (clk),
    .load (req_fire),
    .word (req.inst_addr[ADDR_W-1:2]),
    .slot (slot)
  );

  // write side: clearing pass, or write-back of an update transaction
  assign ram_re = (state == ST_INDEX);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = eval.wr_entry;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else if (state == ST_LOOKUP && cmd_q == CMD_UPDATE) begin
      ram_we = 1'b1;
    end
  end

  btb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot),
    .rdata (rd_entry)
  );

  btb_eval u_eval (
    .rd_entry      (rd_entry),
    .inst_addr     (addr_q),
    .was_taken     (taken_q),
    .actual_target (target_q),
    .result        (eval)
  );

  // a prediction waits in lookup until the response register is free
  assign rsp_load    = (state == ST_LOOKUP) && (cmd_q == CMD_PREDICT)
                       && (!rsp.valid || rsp.ready);
  assign lookup_done = (state == ST_LOOKUP) && ((cmd_q == CMD_UPDATE) || rsp_load);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_fire) begin
            state <= ST_INDEX;
          end
        end
        ST_INDEX: begin
          state <= ST_LOOKUP;
        end
        ST_LOOKUP: begin
          if (lookup_done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase

      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd_q    <= cmd_t'(req.cmd);
      addr_q   <= req.inst_addr;
      taken_q  <= req.was_taken;
      target_q <= req.actual_target;
    end
    if (rsp_load) begin
      rsp.predict_taken <= eval.predict_taken;
      rsp.next_addr     <= eval.next_addr;
    end
  end

  // an accepted transaction reads the table the next cycle, then reaches the lookup
  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (state == ST_INDEX) ##1 (state == ST_LOOKUP))
    else $error("accepted transaction did not reach the lookup");

  // the table is never read and written in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("entry ram read and write overlap");

  // a new response only ever follows a prediction lookup
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_LOOKUP && cmd_q == CMD_PREDICT))
    else $error("response raised without a prediction lookup");

  // no write-back happens for a prediction
  a_predict_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP && cmd_q == CMD_PREDICT) |-> !ram_we)
    else $error("prediction wrote the table");

endmodule

// File: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the two-bit branch target buffer
// drives lookup and commit-update transactions through the request
// channel, keeps a shadow copy of the table to work out each prediction,
// and checks every response in order under random idling and stalls
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import btb_pkg::*;

  localparam int N_ENTRIES = 1024;
  localparam int N_HOT     = 24;

  typedef struct packed {
    logic              predict_taken;
    logic [ADDR_W-1:0] next_addr;
  } prediction_t;

  logic clk = 1'b0;
  logic rst;

  btb_req_if req_ch ();
  btb_rsp_if rsp_ch ();

  btb_two_bit_branch_predictor_top #(
    .ENTRIES (N_ENTRIES)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // 2 ns period, high and low phase of 1 ns each
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the branch table, only read where the valid bit is set
  bit              shadow_valid  [N_ENTRIES];
  bit [ADDR_W-1:0] shadow_tag    [N_ENTRIES];
  bit [ADDR_W-1:0] shadow_target [N_ENTRIES];
  bit [1:0]        shadow_ctr    [N_ENTRIES];

  // predictions still owed by the block, oldest first
  prediction_t expected_predictions [$];

  // hot branch addresses for the random traffic, some sharing a slot
  logic [ADDR_W-1:0] hot_pc [N_HOT];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_cycles_left;

  int unsigned mismatches;
  int unsigned n_lookups;
  int unsigned n_updates;
  int unsigned n_taken_seen;

  // apply one accepted transaction to the shadow table; a lookup queues
  // the prediction the block must give for it
  function automatic void shadow_apply(cmd_t cmd, logic [ADDR_W-1:0] pc, logic taken,
                                       logic [ADDR_W-1:0] target);
    int unsigned slot;
    bit          hit;
    prediction_t p;
    slot = (pc >> 2) % N_ENTRIES;
    hit  = shadow_valid[slot] && (shadow_tag[slot] == pc);
    if (cmd == CMD_PREDICT) begin
      p.predict_taken = hit && (shadow_ctr[slot] >= CTR_WEAK_T);
      p.next_addr     = p.predict_taken ? shadow_target[slot] : pc + INST_BYTES;
      expected_predictions.push_back(p);
    end else if (hit) begin
      // trained entry: target always overwritten, counter steps with this
      // table's rule (weak not-taken jumps straight to strong taken)
      shadow_target[slot] = target;
      if (taken) begin
        shadow_ctr[slot] = (shadow_ctr[slot] == CTR_STRONG_NT) ? CTR_WEAK_NT : CTR_STRONG_T;
      end else begin
        shadow_ctr[slot] = (shadow_ctr[slot] == CTR_STRONG_T) ? CTR_WEAK_T : CTR_STRONG_NT;
      end
    end else begin
      // miss: allocate, replacing whatever held the slot
      shadow_valid[slot]  = 1'b1;
      shadow_tag[slot]    = pc;
      shadow_target[slot] = target;
      shadow_ctr[slot]    = taken ? CTR_WEAK_NT : CTR_STRONG_NT;
    end
  endfunction

  // offer one transaction, with a random idle gap first, and hold it until
  // the block takes it; valid stays high afterwards for back-to-back sends
  task automatic send_request(cmd_t cmd, logic [ADDR_W-1:0] pc, logic taken,
                              logic [ADDR_W-1:0] target);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.cmd           <= cmd;
    req_ch.inst_addr     <= pc;
    req_ch.was_taken     <= taken;
    req_ch.actual_target <= target;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    shadow_apply(cmd, pc, taken, target);
    if (cmd == CMD_PREDICT) n_lookups++;
    else n_updates++;
  endtask

  // lower valid and wait for every owed prediction, bounded by max_cycles;
  // always waits on a clock edge before it checks, so valid is not re-raised in the same step
  task automatic wait_for_drain(int unsigned max_cycles);
    int unsigned waited;
    waited = 0;
    req_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (expected_predictions.size() != 0 && waited < max_cycles);
  endtask

  // ---- directed tests -----------------------------------------------------

  // empty table: every lookup misses, including the wrap of pc + 4
  task automatic test_empty_table();
    send_request(CMD_PREDICT, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF);
    send_request(CMD_PREDICT, 32'hFFFF_FFFC, 1'b0, 32'h0000_0000);
    send_request(CMD_PREDICT, 32'hFFFF_FFFF, 1'b1, 32'h1234_5678);
    send_request(CMD_PREDICT, 32'h8000_0000, 1'b1, 32'hA5A5_A5A5);
  endtask

  // walk one entry through every counter transition, checking the
  // prediction at each strength
  task automatic test_counter_walk();
    logic [ADDR_W-1:0] pc;
    pc = 32'h0000_1000;
    send_request(CMD_UPDATE,  pc, 1'b1, 32'h0000_2000);  // allocate weak not-taken
    send_request(CMD_PREDICT, pc, 1'b0, 32'h0);
    send_request(CMD_UPDATE,  pc, 1'b1, 32'h0000_3000);  // weak nt -> strong taken
    send_request(CMD_PREDICT, pc, 1'b0, 32'h0);
    send_request(CMD_UPDATE,  pc, 1'b1, 32'hFFFF_FFF0);  // saturate, new target
    send_request(CMD_PREDICT, pc, 1'b1, 32'h0);
    send_request(CMD_UPDATE,  pc, 1'b0, 32'h0000_4000);  // strong -> weak taken
    send_request(CMD_PREDICT, pc, 1'b0, 32'h0);
    send_request(CMD_UPDATE,  pc, 1'b1, 32'h0000_5000);  // weak taken -> strong
    send_request(CMD_UPDATE,  pc, 1'b0, 32'h0000_6000);
    send_request(CMD_UPDATE,  pc, 1'b0, 32'h0000_7000);  // weak taken -> strong nt
    send_request(CMD_PREDICT, pc, 1'b0, 32'h0);
    send_request(CMD_UPDATE,  pc, 1'b0, 32'h0000_8000);  // stays strong nt
    send_request(CMD_UPDATE,  pc, 1'b1, 32'h0000_9000);  // strong nt -> weak nt
    send_request(CMD_UPDATE,  pc, 1'b0, 32'h0000_A000);  // weak nt -> strong nt
    send_request(CMD_PREDICT, pc, 1'b1, 32'hFFFF_FFFF);
    // fresh allocation on a not-taken branch
    send_request(CMD_UPDATE,  32'h0000_0008, 1'b0, 32'h0000_0100);
    send_request(CMD_PREDICT, 32'h0000_0008, 1'b0, 32'h0);
  endtask

  // slot conflicts and full-pc tags: an alias evicts, a byte offset misses
  task automatic test_alias_and_tag();
    logic [ADDR_W-1:0] pc;
    pc = 32'hFFFF_FFFC;
    send_request(CMD_UPDATE,  pc, 1'b1, 32'h0000_0000);
    send_request(CMD_UPDATE,  pc, 1'b1, 32'h0000_0000);
    send_request(CMD_PREDICT, pc, 1'b0, 32'h0);                        // taken to zero
    send_request(CMD_PREDICT, 32'hFFFF_FFFD, 1'b0, 32'h0);             // same word, other tag
    send_request(CMD_UPDATE,  pc - 32'(4 * N_ENTRIES), 1'b1, 32'h0);   // evicts
    send_request(CMD_PREDICT, pc, 1'b0, 32'h0);                        // miss, wraps to 0
  endtask

  // ---- random traffic ----------------------------------------------------

  task automatic build_hot_set();
    for (int i = 0; i < N_HOT; i++) begin
      if (i % 4 == 3) hot_pc[i] = hot_pc[i-1] + 32'(4 * N_ENTRIES);
      else if (i % 7 == 5) hot_pc[i] = $urandom();
      else hot_pc[i] = $urandom() & 32'hFFFF_FFFC;
    end
    hot_pc[0] = 32'hFFFF_FFFC;
  endtask

  // mostly training and lookups on the hot set, the rest fully random
  task automatic send_random_item();
    cmd_t              cmd;
    logic [ADDR_W-1:0] pc;
    logic              taken;
    if ($urandom_range(99) < 75) begin
      pc    = hot_pc[$urandom_range(N_HOT - 1)];
      cmd   = cmd_t'($urandom_range(1));
      taken = ($urandom_range(99) < 65);
    end else begin
      pc    = $urandom();
      cmd   = cmd_t'($urandom_range(1));
      taken = 1'($urandom_range(1));
    end
    send_request(cmd, pc, taken, $urandom());
  endtask

  task automatic test_random_traffic(int unsigned n_items, int unsigned s_pct,
                                     int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n_items) send_random_item();
  endtask

  // receiver holds off for a long stretch while lookups keep coming,
  // so the block fills and stalls its request side
  task automatic test_backpressure();
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    stall_cycles_left = 200;
    repeat (40) send_request(CMD_PREDICT, hot_pc[$urandom_range(N_HOT - 1)],
                             1'($urandom_range(1)), $urandom());
  endtask

  // sender pauses until every owed prediction is back, then resumes
  task automatic test_drain_pause();
    send_idle_pct = 10;
    recv_idle_pct = 30;
    repeat (15) send_random_item();
    wait_for_drain(5000);
    repeat (15) send_random_item();
  endtask

  // ---- response checking -------------------------------------------------

  always @(posedge clk) begin
    prediction_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_predictions.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected response: taken=%0b next=%08h",
                   rsp_ch.predict_taken, rsp_ch.next_addr);
        mismatches++;
      end else begin
        want = expected_predictions.pop_front();
        if (rsp_ch.predict_taken) n_taken_seen++;
        if (rsp_ch.predict_taken !== want.predict_taken) begin
          if (mismatches < 10)
            $display("predict_taken mismatch: expected %0b actual %0b",
                     want.predict_taken, rsp_ch.predict_taken);
          mismatches++;
        end
        if (rsp_ch.next_addr !== want.next_addr) begin
          if (mismatches < 10)
            $display("next_addr mismatch: expected %08h actual %08h",
                     want.next_addr, rsp_ch.next_addr);
          mismatches++;
        end
      end
    end
  end

  // response ready: long hold-off when requested, else random idling
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_cycles_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_cycles_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---- main sequence -----------------------------------------------------

  initial begin
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    stall_cycles_left = 0;
    mismatches        = 0;
    n_lookups         = 0;
    n_updates         = 0;
    n_taken_seen      = 0;
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.cmd           <= CMD_PREDICT;
    req_ch.inst_addr     <= '0;
    req_ch.was_taken     <= 1'b0;
    req_ch.actual_target <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // the clearing pass after reset shows up as ready held low
    test_empty_table();
    test_counter_walk();
    test_alias_and_tag();

    build_hot_set();
    test_random_traffic(240, 18, 49);
    test_random_traffic(240, 49, 18);
    test_random_traffic(230, 0, 0);
    test_backpressure();
    test_drain_pause();

    // drain, then keep the clock running quiet in case anything stray comes out
    wait_for_drain(20000);
    repeat (10) @(posedge clk);
    mismatches += expected_predictions.size();

    $display("summary: %0d lookups and %0d updates sent, %0d predictions taken",
             n_lookups, n_updates, n_taken_seen);
    $display("summary: idle mixes, a long response stall and a full drain covered");
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #400000;
    $display("testbench: errors");
    $finish;
  end

endmodule

// File: btb_two_bit_branch_predictor_top.f
rtl/btb_pkg.sv
rtl/btb_req_if.sv
rtl/btb_rsp_if.sv
rtl/btb_ram.sv
rtl/btb_slot.sv
rtl/btb_eval.sv
rtl/btb_two_bit_branch_predictor_top.sv
test/testbench.sv
